// ===== design/igsdp_pkg.sv =====
package igsdp_pkg;

   localparam int LANES       = 8;
   localparam int SMALL_GROUP = 32;
   localparam int LARGE_GROUP = 128;
   localparam int CNT_W       = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CNT_W:0] SMALL_ITEMS = (CNT_W + 1)'(SMALL_GROUP / LANES);
   localparam logic [CNT_W:0] LARGE_ITEMS = (CNT_W + 1)'(LARGE_GROUP / LANES);

   localparam logic [0:0] REG_GROUP_MODE = 1'b0;

   typedef enum logic {
      GROUP_32  = 1'b0,
      GROUP_128 = 1'b1
   } group_mode_type;

   typedef struct packed {
      logic signed [15:0] act_7;
      logic signed [15:0] act_6;
      logic signed [15:0] act_5;
      logic signed [15:0] act_4;
      logic signed [15:0] act_3;
      logic signed [15:0] act_2;
      logic signed [15:0] act_1;
      logic signed [15:0] act_0;
      logic [31:0]        weight_nibbles;
      logic signed [15:0] group_scale;
      logic               row_last;
   } req_type;

   typedef struct packed {
      logic signed [63:0] dot_result;
      logic               misaligned_end;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic signed [15:0] scale;
   } stage_ctrl_type;

endpackage

// ===== design/igsdp_lane.sv =====
module igsdp_lane #(
   parameter int ACT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [15:0]               act,
   input  logic [3:0]                nibble,
   output logic signed [ACT_BITS+3:0] product_ff
);
   import igsdp_pkg::*;

   localparam int PW = ACT_BITS + 4;

   logic [ACT_BITS+15:0]       act_wide;
   logic signed [ACT_BITS-1:0] act_s;
   logic signed [PW-1:0]       act_ext;
   logic signed [PW-1:0]       wgt_ext;
   logic signed [PW-1:0]       product_in;

   assign act_wide   = {{ACT_BITS{1'b0}}, act};
   assign act_s      = act_wide[ACT_BITS-1:0];
   assign act_ext    = {{4{act_s[ACT_BITS-1]}}, act_s};
   assign wgt_ext    = {{ACT_BITS{nibble[3]}}, nibble};
   assign product_in = act_ext * wgt_ext;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

endmodule

// ===== design/igsdp_merge.sv =====
module igsdp_merge #(
   parameter int ACT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic signed [ACT_BITS+3:0] products [igsdp_pkg::LANES],
   output logic signed [ACT_BITS+6:0] part_ff
);
   import igsdp_pkg::*;

   localparam int SW = ACT_BITS + 7;

   logic signed [SW-1:0] part_in;

   always_comb begin
      part_in = '0;
      for (int i = 0; i < LANES; i++) begin
         part_in = part_in + SW'(products[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         part_ff <= part_in;
      end
   end

endmodule

// ===== design/igsdp_accum.sv =====
module igsdp_accum #(
   parameter int ACT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  igsdp_pkg::group_mode_type  group_mode,
   input  igsdp_pkg::stage_ctrl_type  ctrl,
   input  logic signed [ACT_BITS+6:0] part,
   output igsdp_pkg::rsp_type         rsp_ff,
   output logic                       rsp_valid_ff
);
   import igsdp_pkg::*;

   localparam int GW = ACT_BITS + 11;
   localparam int MW = GW + 16;

   logic signed [GW-1:0] gacc_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic signed [GW-1:0] gacc_in;
   logic [CNT_W-1:0]     cnt_in;
   logic [CNT_W:0]       group_items;
   logic                 grp_end;
   logic                 close;

   logic signed [GW-1:0] gsum_ff;
   logic signed [15:0]   gscale_ff;
   logic                 gv_ff;
   logic                 gclose_ff;
   logic                 glast_ff;
   logic                 gmis_ff;

   logic signed [MW-1:0] prod_in;
   logic signed [MW-1:0] prod_ff;
   logic                 mv_ff;
   logic                 mclose_ff;
   logic                 mlast_ff;
   logic                 mmis_ff;

   logic signed [63:0]   row_ff;
   logic signed [63:0]   row_in;
   logic                 rsp_valid_in;

   assign gacc_in     = gacc_ff + GW'(part);
   assign cnt_in      = cnt_ff + CNT_W'(1);
   assign group_items = (group_mode == GROUP_128) ? LARGE_ITEMS : SMALL_ITEMS;
   assign grp_end     = (cnt_in == '0) || ({1'b0, cnt_in} >= group_items);
   assign close       = grp_end || ctrl.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         gacc_ff   <= '0;
         cnt_ff    <= '0;
         gv_ff     <= 1'b0;
         gclose_ff <= 1'b0;
         glast_ff  <= 1'b0;
      end else if (enable) begin
         gv_ff     <= ctrl.valid;
         gclose_ff <= ctrl.valid && close;
         glast_ff  <= ctrl.valid && ctrl.last;
         if (ctrl.valid) begin
            if (close) begin
               gacc_ff <= '0;
               cnt_ff  <= '0;
            end else begin
               gacc_ff <= gacc_in;
               cnt_ff  <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         gsum_ff   <= gacc_in;
         gscale_ff <= ctrl.scale;
         gmis_ff   <= !grp_end;
      end
   end

   assign prod_in = MW'(gsum_ff) * MW'(gscale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff     <= 1'b0;
         mclose_ff <= 1'b0;
         mlast_ff  <= 1'b0;
      end else if (enable) begin
         mv_ff     <= gv_ff;
         mclose_ff <= gclose_ff;
         mlast_ff  <= glast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         mmis_ff <= gmis_ff;
      end
   end

   assign row_in       = mclose_ff ? (row_ff + 64'(prod_ff)) : row_ff;
   assign rsp_valid_in = mv_ff && mlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= rsp_valid_in;
         if (mv_ff) begin
            row_ff <= rsp_valid_in ? 64'sd0 : row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable && rsp_valid_in) begin
         rsp_ff.dot_result     <= row_in;
         rsp_ff.misaligned_end <= mmis_ff;
      end
   end

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      glast_ff |-> gclose_ff)
      else $error("row end did not close its group");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      gv_ff && gclose_ff |-> cnt_ff == '0 && gacc_ff == '0)
      else $error("group state not cleared after close");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(mv_ff && mlast_ff))
      else $error("result without a row end");

   a_stall_holds_row: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(row_ff) && $stable(gacc_ff))
      else $error("accumulator moved during stall");

endmodule

// ===== design/int4_group_scaled_dot_product.sv =====
// A row's last word passes lane, tree, group and scale registers to rsp_valid.
// Throughput: one word per cycle when not stalled; eight multiply lanes feed
// one adder tree and a single group-scale multiplier, all in one stalling
// pipeline. The whole pipeline holds while a result waits on rsp_ready.
// Reset (synchronous): clears group and row sums, item count, pipeline
// valids and group_mode (groups of 32).
module int4_group_scaled_dot_product #(
   parameter int ACT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  igsdp_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output igsdp_pkg::rsp_type                  rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [igsdp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [igsdp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [igsdp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import igsdp_pkg::*;

   logic                        advance;
   group_mode_type              group_mode_ff;
   logic [LANES-1:0][15:0]      acts;
   logic signed [ACT_BITS+3:0]  products [LANES];
   logic signed [ACT_BITS+6:0]  part;
   stage_ctrl_type              s1_ctrl_ff;
   stage_ctrl_type              s2_ctrl_ff;
   stage_ctrl_type              s1_ctrl_in;
   logic                        csr_write;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_mode_ff <= GROUP_32;
      end else if (csr_write && (csr_paddr[2:2] == REG_GROUP_MODE)) begin
         group_mode_ff <= group_mode_type'(csr_pwdata[0]);
      end
   end

   always_comb begin
      case (csr_paddr[2:2])
         REG_GROUP_MODE: csr_prdata = CSR_DATA_W'(group_mode_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign acts = {req_data.act_7, req_data.act_6, req_data.act_5, req_data.act_4,
                  req_data.act_3, req_data.act_2, req_data.act_1, req_data.act_0};

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      igsdp_lane #(
         .ACT_BITS (ACT_BITS)
      ) u_lane (
         .clock      (clock),
         .enable     (advance),
         .act        (acts[g]),
         .nibble     (req_data.weight_nibbles[4*g +: 4]),
         .product_ff (products[g])
      );
   end

   igsdp_merge #(
      .ACT_BITS (ACT_BITS)
   ) u_merge (
      .clock    (clock),
      .enable   (advance),
      .products (products),
      .part_ff  (part)
   );

   assign s1_ctrl_in.valid = req_valid;
   assign s1_ctrl_in.last  = req_data.row_last;
   assign s1_ctrl_in.scale = req_data.group_scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff.valid <= 1'b0;
         s2_ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   igsdp_accum #(
      .ACT_BITS (ACT_BITS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .group_mode   (group_mode_ff),
      .ctrl         (s2_ctrl_ff),
      .part         (part),
      .rsp_ff       (rsp_data),
      .rsp_valid_ff (rsp_valid)
   );

endmodule
